// ----- hdl/assert_macros.svh -----
// assert_macros.svh: assertion helpers for the particle pool checkers.
// Each macro expects a signal named clk, and CHK_ON also rst, in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants for the particle pool update block
// Field widths, fixed-point constants, opcodes, register indexes, the command
// record passed from the front end to the back end, and the saturation helper.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int PARTICLES_DEF = 32;
  localparam int PARTICLES_MAX = 64;
  localparam int SLOT_W        = 6;
  localparam int FIX_W         = 32;
  localparam int SHADE_W       = 7;
  localparam int DT_W          = 20;
  localparam int JIT_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int WIDE_W        = 40;

  // life of a fresh particle: 10.0 in Q16.16
  localparam logic signed [FIX_W-1:0] LIFE_FULL = 32'sd655360;
  // velocity scale 0.1 is a rounded divide by this constant
  localparam int VEL_DIV   = 10;
  // reciprocal of ten: floor(n * VEL_RECIP >> VEL_SHIFT) is n / 10 for any 32-bit n
  localparam logic [FIX_W-1:0] VEL_RECIP = 32'hCCCCCCCD;
  localparam int VEL_SHIFT = 35;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  typedef enum logic {
    OP_SPAWN   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_SPAWN,
    B_RD,
    B_MUL,
    B_RND,
    B_UPD
  } back_state_t;

  typedef struct packed {
    op_t                      op;
    logic signed [FIX_W-1:0]  pos_x;
    logic signed [FIX_W-1:0]  pos_y;
    logic signed [FIX_W-1:0]  pos_z;
    logic signed [FIX_W-1:0]  vel_x;
    logic signed [FIX_W-1:0]  vel_y;
    logic signed [FIX_W-1:0]  vel_z;
    logic [SHADE_W-1:0]       shade;
    logic [DT_W-1:0]          dt;
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = -40'sh0080000000;
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[FIX_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/ppu_queue.sv -----
// ----------------------------------------------------------------------------
// ppu_queue: short command queue between front end and back end
// Two-entry register queue; the head entry is read at the read pointer only.
// ----------------------------------------------------------------------------
module ppu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppu_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output ppu_pkg::cmd_t   head,
  output ppu_pkg::q_stat_t stat
);

  ppu_pkg::cmd_t entry [ppu_pkg::Q_DEPTH];
  logic [ppu_pkg::Q_PTR_W-1:0] wptr;
  logic [ppu_pkg::Q_PTR_W-1:0] rptr;
  logic [ppu_pkg::Q_PTR_W:0]   count;

  assign head       = entry[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (ppu_pkg::Q_PTR_W+1)'(ppu_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

endmodule

// ----- hdl/ppu_front.sv -----
// ----------------------------------------------------------------------------
// ppu_front: item intake, offset registers and spawn preparation
// Takes one item, forms the spawn position and, for a spawn, scales the three
// velocity components by a tenth with a reciprocal multiply; every item is then queued.
// ----------------------------------------------------------------------------
module ppu_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                opcode,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_x,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_y,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_z,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_x,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_y,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_z,
  input  logic signed [ppu_pkg::JIT_W-1:0]    jitter,
  input  logic [ppu_pkg::SHADE_W-1:0]         shade_pick,
  input  logic [ppu_pkg::DT_W-1:0]            step_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppu_pkg::FIX_W-1:0]           cfg_data,
  output logic                                push,
  output ppu_pkg::cmd_t                       push_cmd,
  input  ppu_pkg::q_stat_t                    q_stat
);

  localparam int LANES = 3;
  localparam int NUM_W = ppu_pkg::FIX_W + 1;

  ppu_pkg::front_state_t state, state_next;

  ppu_pkg::op_t                    op;
  logic signed [ppu_pkg::FIX_W-1:0] pos [LANES];
  logic signed [ppu_pkg::FIX_W-1:0] offset [LANES];
  logic signed [ppu_pkg::JIT_W-1:0] jit;
  logic [ppu_pkg::SHADE_W-1:0]     shade;
  logic [ppu_pkg::DT_W-1:0]        dt;
  logic [NUM_W-1:0]                num [LANES];
  logic [ppu_pkg::FIX_W-1:0]       quo [LANES];
  logic                            neg [LANES];
  logic [2*ppu_pkg::FIX_W-1:0]     recip [LANES];

  logic                            take;
  logic signed [ppu_pkg::FIX_W-1:0] vel_in [LANES];
  logic signed [ppu_pkg::FIX_W-1:0] pos_out [LANES];
  logic signed [ppu_pkg::FIX_W-1:0] vel_out [LANES];
  logic signed [ppu_pkg::WIDE_W-1:0] jit_wide;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ppu_pkg::F_IDLE);
  assign take       = item_valid && !item_stall;

  assign vel_in[0] = src_vel_x;
  assign vel_in[1] = src_vel_y;
  assign vel_in[2] = src_vel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0] <= '0;
      offset[1] <= '0;
      offset[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppu_pkg::REG_OFFSET_X: offset[0] <= cfg_data;
        ppu_pkg::REG_OFFSET_Y: offset[1] <= cfg_data;
        ppu_pkg::REG_OFFSET_Z: offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppu_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    case (state)
      ppu_pkg::F_IDLE: begin
        if (take) begin
          state_next = (opcode == ppu_pkg::OP_ADVANCE) ? ppu_pkg::F_PUSH : ppu_pkg::F_DIV;
        end
      end
      ppu_pkg::F_DIV: begin
        state_next = ppu_pkg::F_PUSH;
      end
      ppu_pkg::F_PUSH: begin
        if (!q_stat.full) begin
          push       = 1'b1;
          state_next = ppu_pkg::F_IDLE;
        end
      end
      default: state_next = ppu_pkg::F_IDLE;
    endcase
  end

  // (|v| + 5) / 10 by multiplying with the reciprocal of ten
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      recip[k] = {32'b0, num[k][ppu_pkg::FIX_W-1:0]} * {32'b0, ppu_pkg::VEL_RECIP};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op     <= ppu_pkg::op_t'(opcode);
      pos[0] <= src_pos_x;
      pos[1] <= src_pos_y;
      pos[2] <= src_pos_z;
      jit    <= jitter;
      shade  <= shade_pick;
      dt     <= step_time;
      for (int k = 0; k < LANES; k++) begin
        neg[k] <= vel_in[k][ppu_pkg::FIX_W-1];
        num[k] <= (vel_in[k][ppu_pkg::FIX_W-1]
                   ? (-{vel_in[k][ppu_pkg::FIX_W-1], vel_in[k]})
                   : {vel_in[k][ppu_pkg::FIX_W-1], vel_in[k]})
                  + NUM_W'(ppu_pkg::VEL_DIV / 2);
      end
    end else if (state == ppu_pkg::F_DIV) begin
      for (int k = 0; k < LANES; k++) begin
        quo[k] <= ppu_pkg::FIX_W'(recip[k] >> ppu_pkg::VEL_SHIFT);
      end
    end
  end

  assign jit_wide = {{(ppu_pkg::WIDE_W-ppu_pkg::JIT_W-16){jit[ppu_pkg::JIT_W-1]}}, jit, 16'b0};

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      pos_out[k] = ppu_pkg::sat32(
          {{(ppu_pkg::WIDE_W-ppu_pkg::FIX_W){pos[k][ppu_pkg::FIX_W-1]}}, pos[k]}
        + {{(ppu_pkg::WIDE_W-ppu_pkg::FIX_W){offset[k][ppu_pkg::FIX_W-1]}}, offset[k]}
        + jit_wide);
      vel_out[k] = neg[k] ? -quo[k] : quo[k];
    end
  end

  always_comb begin
    push_cmd.op    = op;
    push_cmd.pos_x = pos_out[0];
    push_cmd.pos_y = pos_out[1];
    push_cmd.pos_z = pos_out[2];
    push_cmd.vel_x = vel_out[0];
    push_cmd.vel_y = vel_out[1];
    push_cmd.vel_z = vel_out[2];
    push_cmd.shade = shade;
    push_cmd.dt    = dt;
  end

endmodule

// ----- hdl/ppu_back.sv -----
// ----------------------------------------------------------------------------
// ppu_back: particle stores, spawn slot scan and per-slot advance sequencer
// Spawn scans alive flags one slot a cycle; advance steps through every slot:
// read, multiply, round, update and hand the result to the output register.
// ----------------------------------------------------------------------------
module ppu_back #(
  parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ppu_pkg::cmd_t                       head,
  input  ppu_pkg::q_stat_t                    q_stat,
  output logic                                pop,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [ppu_pkg::SLOT_W-1:0]          slot,
  output logic                                alive,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_x,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_y,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_z,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_alpha,
  output logic [ppu_pkg::SHADE_W-1:0]         out_shade,
  output logic                                last
);

  localparam int IDX_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int LANES  = 3;
  localparam int PROD_W = ppu_pkg::FIX_W + ppu_pkg::DT_W + 1;
  localparam int RND_W  = PROD_W - 15;
  localparam int FADE_W = ppu_pkg::DT_W + 3;
  localparam int FW     = ppu_pkg::FIX_W;
  localparam int WW     = ppu_pkg::WIDE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARTICLES - 1);
  localparam logic [IDX_W:0]   IDX_CNT  = (IDX_W+1)'(PARTICLES);

  ppu_pkg::back_state_t state, state_next;

  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     cnt;
  logic [IDX_W-1:0]     last_used;
  logic [IDX_W-1:0]     spawn_slot;
  logic [PARTICLES-1:0] live_bits;

  logic signed [FW-1:0] life_mem  [PARTICLES];
  logic signed [FW-1:0] pos_mem   [LANES][PARTICLES];
  logic signed [FW-1:0] vel_mem   [LANES][PARTICLES];
  logic signed [FW-1:0] alpha_mem [PARTICLES];
  logic [ppu_pkg::SHADE_W-1:0] shade_mem [PARTICLES];

  logic signed [FW-1:0] rd_life;
  logic signed [FW-1:0] rd_pos [LANES];
  logic signed [FW-1:0] rd_vel [LANES];
  logic signed [FW-1:0] rd_alpha;
  logic [ppu_pkg::SHADE_W-1:0] rd_shade;

  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [RND_W-1:0]  step [LANES];
  logic signed [FW:0]       life_new;
  logic                     live;

  logic [IDX_W:0]           cand_sum;
  logic [IDX_W-1:0]         cand;
  logic                     out_free;
  logic                     upd_go;
  logic                     spawn_we;
  logic                     upd_we;
  logic [IDX_W-1:0]         wa;
  logic signed [FW-1:0]     lf;
  logic signed [ppu_pkg::DT_W:0] dt_s;
  logic [FADE_W-1:0]        fade;
  logic signed [FW-1:0]     npos [LANES];
  logic signed [FW-1:0]     nalpha;
  logic signed [FW-1:0]     spawn_pos [LANES];
  logic signed [FW-1:0]     spawn_vel [LANES];
  logic [PROD_W-1:0]        pmag [LANES];
  logic [RND_W-1:0]         qmag [LANES];

  assign out_free = !res_valid || !res_stall;
  assign upd_go   = (state == ppu_pkg::B_UPD) && out_free;
  assign spawn_we = (state == ppu_pkg::B_SPAWN);
  assign upd_we   = upd_go && live;
  assign wa       = spawn_we ? spawn_slot : idx;

  // wrap the scan position past the end of the pool
  assign cand_sum = {1'b0, last_used} + {1'b0, cnt};
  assign cand     = (cand_sum >= IDX_CNT) ? IDX_W'(cand_sum - IDX_CNT) : cand_sum[IDX_W-1:0];

  assign dt_s = $signed({1'b0, head.dt});
  assign fade = FADE_W'(({3'b0, head.dt} * 23'd5 + 23'd1) >> 1);
  assign lf   = live_bits[idx] ? rd_life : '0;

  assign spawn_pos[0] = head.pos_x;
  assign spawn_pos[1] = head.pos_y;
  assign spawn_pos[2] = head.pos_z;
  assign spawn_vel[0] = head.vel_x;
  assign spawn_vel[1] = head.vel_y;
  assign spawn_vel[2] = head.vel_z;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      npos[k] = ppu_pkg::sat32({{(WW-FW){rd_pos[k][FW-1]}}, rd_pos[k]}
                             - {{(WW-RND_W){step[k][RND_W-1]}}, step[k]});
      pmag[k] = prod[k][PROD_W-1] ? PROD_W'(-prod[k]) : PROD_W'(prod[k]);
      qmag[k] = RND_W'((pmag[k] + PROD_W'(32768)) >> 16);
    end
    nalpha = ppu_pkg::sat32({{(WW-FW){rd_alpha[FW-1]}}, rd_alpha}
                          - {{(WW-FADE_W){1'b0}}, fade});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppu_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      ppu_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (head.op == ppu_pkg::OP_SPAWN) ? ppu_pkg::B_SCAN : ppu_pkg::B_RD;
        end
      end
      ppu_pkg::B_SCAN: begin
        if (!live_bits[cand] || cnt == IDX_LAST) begin
          state_next = ppu_pkg::B_SPAWN;
        end
      end
      ppu_pkg::B_SPAWN: begin
        pop        = 1'b1;
        state_next = ppu_pkg::B_IDLE;
      end
      ppu_pkg::B_RD:  state_next = ppu_pkg::B_MUL;
      ppu_pkg::B_MUL: state_next = ppu_pkg::B_RND;
      ppu_pkg::B_RND: state_next = ppu_pkg::B_UPD;
      ppu_pkg::B_UPD: begin
        if (out_free) begin
          if (idx == IDX_LAST) begin
            pop        = 1'b1;
            state_next = ppu_pkg::B_IDLE;
          end else begin
            state_next = ppu_pkg::B_RD;
          end
        end
      end
      default: state_next = ppu_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_bits <= '0;
      last_used <= '0;
      res_valid <= 1'b0;
    end else begin
      if (spawn_we) begin
        live_bits[spawn_slot] <= 1'b1;
        last_used             <= spawn_slot;
      end else if (upd_go) begin
        live_bits[idx] <= live;
      end
      if (upd_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ppu_pkg::B_IDLE: begin
        idx <= '0;
        cnt <= '0;
      end
      ppu_pkg::B_SCAN: begin
        cnt <= cnt + 1'b1;
        if (!live_bits[cand]) begin
          spawn_slot <= cand;
        end else begin
          spawn_slot <= '0;
        end
      end
      ppu_pkg::B_MUL: begin
        life_new <= $signed({lf[FW-1], lf}) - $signed({{(FW+1-ppu_pkg::DT_W){1'b0}}, head.dt});
        for (int k = 0; k < LANES; k++) begin
          prod[k] <= rd_vel[k] * dt_s;
        end
      end
      ppu_pkg::B_RND: begin
        live <= !life_new[FW] && (life_new != '0);
        for (int k = 0; k < LANES; k++) begin
          step[k] <= prod[k][PROD_W-1] ? -$signed(qmag[k]) : $signed(qmag[k]);
        end
      end
      ppu_pkg::B_UPD: begin
        if (out_free && idx != IDX_LAST) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register, loaded as each slot finishes
  always_ff @(posedge clk) begin
    if (upd_go) begin
      slot      <= ppu_pkg::SLOT_W'(idx);
      alive     <= live;
      out_pos_x <= live ? npos[0] : '0;
      out_pos_y <= live ? npos[1] : '0;
      out_pos_z <= live ? npos[2] : '0;
      out_alpha <= live ? nalpha : '0;
      out_shade <= live ? rd_shade : '0;
      last      <= (idx == IDX_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (spawn_we || upd_we) begin
      life_mem[wa]  <= spawn_we ? ppu_pkg::LIFE_FULL : life_new[FW-1:0];
      alpha_mem[wa] <= spawn_we ? '0 : nalpha;
      for (int k = 0; k < LANES; k++) begin
        pos_mem[k][wa] <= spawn_we ? spawn_pos[k] : npos[k];
      end
    end
    if (spawn_we) begin
      shade_mem[wa] <= head.shade;
      for (int k = 0; k < LANES; k++) begin
        vel_mem[k][wa] <= spawn_vel[k];
      end
    end
    rd_life  <= life_mem[idx];
    rd_alpha <= alpha_mem[idx];
    rd_shade <= shade_mem[idx];
    for (int k = 0; k < LANES; k++) begin
      rd_pos[k] <= pos_mem[k][idx];
      rd_vel[k] <= vel_mem[k][idx];
    end
  end

endmodule

// ----- hdl/particle_pool_update.sv -----
// A spawn item holds the intake in the front end while its velocity is scaled
// by a tenth and then while the command is queued; the back end then scans
// alive flags one slot per cycle from the last used slot. An advance item steps
// through every slot in the back-end sequencer (store read, multiply, round,
// update), waits out any result stall, and gives PARTICLES results in slot
// order; a two-entry queue lets the front end take and prepare the next item
// meanwhile, and the intake stalls whenever the front end is busy with an item,
// also while it waits on a full queue. The user must write the offset registers
// through the cfg port only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
// particle_pool_update: particle pool spawn and advance engine
// Front end for intake and spawn preparation, command queue, back end holding
// the particle stores and producing one result per slot on advance.
// ----------------------------------------------------------------------------
module particle_pool_update #(
  parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                opcode,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_x,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_y,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_pos_z,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_x,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_y,
  input  logic signed [ppu_pkg::FIX_W-1:0]    src_vel_z,
  input  logic signed [ppu_pkg::JIT_W-1:0]    jitter,
  input  logic [ppu_pkg::SHADE_W-1:0]         shade_pick,
  input  logic [ppu_pkg::DT_W-1:0]            step_time,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [ppu_pkg::SLOT_W-1:0]          slot,
  output logic                                alive,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_x,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_y,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_pos_z,
  output logic signed [ppu_pkg::FIX_W-1:0]    out_alpha,
  output logic [ppu_pkg::SHADE_W-1:0]         out_shade,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppu_pkg::FIX_W-1:0]           cfg_data
);

  logic              push;
  logic              pop;
  ppu_pkg::cmd_t     push_cmd;
  ppu_pkg::cmd_t     head;
  ppu_pkg::q_stat_t  q_stat;

  ppu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .src_pos_x  (src_pos_x),
    .src_pos_y  (src_pos_y),
    .src_pos_z  (src_pos_z),
    .src_vel_x  (src_vel_x),
    .src_vel_y  (src_vel_y),
    .src_vel_z  (src_vel_z),
    .jitter     (jitter),
    .shade_pick (shade_pick),
    .step_time  (step_time),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_stat     (q_stat)
  );

  ppu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ppu_back #(
    .PARTICLES (PARTICLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .slot      (slot),
    .alive     (alive),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_alpha (out_alpha),
    .out_shade (out_shade),
    .last      (last)
  );

endmodule

// ----- hdl/ppu_checker.sv -----
// ----------------------------------------------------------------------------
// ppu_checker: port-level checks for the particle pool update block
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppu_checker #(
  parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_stall,
  input logic [ppu_pkg::SLOT_W-1:0]       slot,
  input logic                             alive,
  input logic signed [ppu_pkg::FIX_W-1:0] out_pos_x,
  input logic signed [ppu_pkg::FIX_W-1:0] out_alpha,
  input logic [ppu_pkg::SHADE_W-1:0]      out_shade,
  input logic                             last
);

  localparam logic [ppu_pkg::SLOT_W-1:0] SLOT_LAST = ppu_pkg::SLOT_W'(PARTICLES - 1);

  // a stalled beat stays offered
  `CHK_ON(a_res_hold, res_valid && res_stall |=> res_valid, "result beat dropped while stalled")

  `CHK_ALWAYS(a_rst_quiet, rst |=> !res_valid, "result offered right after reset")

  `CHK_ON(a_last_slot, res_valid && last |-> slot == SLOT_LAST, "last flag on wrong slot")

  `CHK_ON(a_dead_zero, res_valid && !alive |-> out_pos_x == 0 && out_alpha == 0 && out_shade == 0, "dead slot reports nonzero data")

  // the slot after a taken non-final beat follows in order
  `CHK_ON(a_slot_order, res_valid && !res_stall && !last |=> !res_valid || slot == $past(slot) + 1'b1, "result slots out of order")

endmodule

bind particle_pool_update ppu_checker #(
  .PARTICLES (PARTICLES)
) u_ppu_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .slot      (slot),
  .alive     (alive),
  .out_pos_x (out_pos_x),
  .out_alpha (out_alpha),
  .out_shade (out_shade),
  .last      (last)
);
